// ===== design/mhpq_pkg.sv =====
// Shared types and constants of the max-heap priority queue
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CH_W     = IDX_W + 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OCNT_W   = 11;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned RES_W    = KEY_W + STAT_W + KEY_W + OCNT_W + 1;
  localparam int unsigned OUT_W    = ((RES_W + 7) / 8) * 8;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CH_W-1:0]         child_t;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_LAST_RD,
    ST_LAST_LD,
    ST_DN_RD,
    ST_DN_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               is_empty;
    logic [OCNT_W-1:0]  count;
    key_t               top_value;
    status_e            status;
    key_t               removed_value;
  } res_t;

endpackage

// ===== design/mhpq_out_buf.sv =====
// One-entry result register between the heap sequencer and the output stream
`timescale 1ns / 1ps

module mhpq_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mhpq_pkg::res_t              push_data_i,
  output logic                        push_ready_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // removed_value[31:0], status[33:32], top_value[65:34], count[76:66],
  // is_empty[77], zero pad[79:78]
  output logic [mhpq_pkg::OUT_W-1:0]  m_axis_tdata
);

  logic           valid_q, valid_d;
  mhpq_pkg::res_t data_q;

  assign push_ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (push_i && push_ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && push_ready_o) begin
      data_q <= push_data_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = mhpq_pkg::OUT_W'(data_q);

endmodule

// ===== design/max_heap_priority_queue_unit.sv =====
// Top level of the max-heap priority queue: sequencer, heap memory and root register
//
//  channel | dir | tdata                     | tuser
//  s_axis  | in  | value[31:0]               | kind[0] (0 insert, 1 remove max)
//  m_axis  | out | removed_value, status,    | -
//          |     | top_value, count, is_empty|
//
// An insert climbs from the new slot through ST_UP_RD and ST_UP_CMP per level and may stop
// below the root; a remove reads the last entry (ST_LAST_RD, ST_LAST_LD) and then descends.
// Errors and the removal of the last entry go straight to ST_DONE.
// Each heap level takes a memory read state and a compare/write state.
// Reset clears the count, the sequencer and the output register; the memory is not cleared.
// A result waiting on m_axis stalls the next item only when it reaches its own result.
`timescale 1ns / 1ps

module max_heap_priority_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // value[31:0]
  input  logic [mhpq_pkg::KEY_W-1:0]  s_axis_tdata,
  // kind[0]
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // removed_value[31:0], status[33:32], top_value[65:34], count[76:66],
  // is_empty[77], zero pad[79:78]
  output logic [mhpq_pkg::OUT_W-1:0]  m_axis_tdata
);

  mhpq_pkg::state_e  state_q, state_d;
  mhpq_pkg::cnt_t    count_q, count_d;
  mhpq_pkg::idx_t    idx_q, idx_d;
  mhpq_pkg::key_t    key_q, key_d;
  mhpq_pkg::key_t    root_q, root_d;
  mhpq_pkg::key_t    removed_q, removed_d;
  mhpq_pkg::status_e status_q, status_d;

  mhpq_pkg::key_t    mem [mhpq_pkg::CAPACITY];
  logic              we;
  mhpq_pkg::idx_t    waddr;
  mhpq_pkg::key_t    wdata;
  mhpq_pkg::idx_t    raddr_a, raddr_b;
  mhpq_pkg::key_t    rdata_a_q, rdata_b_q;

  logic              accept;
  logic              push, push_ready;
  mhpq_pkg::res_t    res;

  mhpq_pkg::idx_t    parent;
  mhpq_pkg::child_t  left, right;
  logic              left_ok, right_ok, take_left, take_right;

  assign s_axis_tready = (state_q == mhpq_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign parent   = mhpq_pkg::IDX_W'((idx_q - 1'b1) >> 1);
  assign left     = {1'b0, idx_q, 1'b1};
  assign right    = left + 1'b1;
  assign left_ok  = left < mhpq_pkg::CH_W'(count_q);
  assign right_ok = right < mhpq_pkg::CH_W'(count_q);
  assign take_left  = left_ok && (rdata_a_q > key_q);
  assign take_right = right_ok &&
                      (take_left ? (rdata_b_q > rdata_a_q) : (rdata_b_q > key_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mhpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (mhpq_pkg::kind_e'(s_axis_tuser) == mhpq_pkg::KIND_INSERT) begin
            state_d = (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) ?
                      mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_RD;
          end else begin
            state_d = (count_q <= mhpq_pkg::CNT_W'(1)) ?
                      mhpq_pkg::ST_DONE : mhpq_pkg::ST_LAST_RD;
          end
        end
      end
      mhpq_pkg::ST_UP_RD: begin
        state_d = (idx_q == '0) ? mhpq_pkg::ST_DONE : mhpq_pkg::ST_UP_CMP;
      end
      mhpq_pkg::ST_UP_CMP: begin
        state_d = (key_q > rdata_a_q) ? mhpq_pkg::ST_UP_RD : mhpq_pkg::ST_DONE;
      end
      mhpq_pkg::ST_LAST_RD: state_d = mhpq_pkg::ST_LAST_LD;
      mhpq_pkg::ST_LAST_LD: state_d = mhpq_pkg::ST_DN_RD;
      mhpq_pkg::ST_DN_RD:   state_d = mhpq_pkg::ST_DN_CMP;
      mhpq_pkg::ST_DN_CMP: begin
        state_d = (take_left || take_right) ? mhpq_pkg::ST_DN_RD : mhpq_pkg::ST_DONE;
      end
      mhpq_pkg::ST_DONE: begin
        if (push_ready) begin
          state_d = mhpq_pkg::ST_IDLE;
        end
      end
      default: state_d = mhpq_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    count_d   = count_q;
    idx_d     = idx_q;
    key_d     = key_q;
    removed_d = removed_q;
    status_d  = status_q;
    we        = 1'b0;
    waddr     = idx_q;
    wdata     = key_q;
    raddr_a   = parent;
    raddr_b   = mhpq_pkg::IDX_W'(right);
    push      = 1'b0;
    case (state_q)
      mhpq_pkg::ST_IDLE: begin
        if (accept) begin
          removed_d = '0;
          status_d  = mhpq_pkg::STAT_OK;
          if (mhpq_pkg::kind_e'(s_axis_tuser) == mhpq_pkg::KIND_INSERT) begin
            if (count_q == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY)) begin
              status_d = mhpq_pkg::STAT_FULL;
            end else begin
              idx_d   = mhpq_pkg::IDX_W'(count_q);
              key_d   = s_axis_tdata;
              count_d = count_q + 1'b1;
            end
          end else begin
            if (count_q == '0) begin
              status_d = mhpq_pkg::STAT_EMPTY;
            end else begin
              removed_d = root_q;
              count_d   = count_q - 1'b1;
            end
          end
        end
      end
      mhpq_pkg::ST_UP_RD: begin
        if (idx_q == '0) begin
          we = 1'b1;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        we = 1'b1;
        if (key_q > rdata_a_q) begin
          wdata = rdata_a_q;
          idx_d = parent;
        end
      end
      mhpq_pkg::ST_LAST_RD: begin
        raddr_a = mhpq_pkg::IDX_W'(count_q);
      end
      mhpq_pkg::ST_LAST_LD: begin
        key_d = rdata_a_q;
        idx_d = '0;
      end
      mhpq_pkg::ST_DN_RD: begin
        raddr_a = mhpq_pkg::IDX_W'(left);
      end
      mhpq_pkg::ST_DN_CMP: begin
        we = 1'b1;
        if (take_right) begin
          wdata = rdata_b_q;
          idx_d = mhpq_pkg::IDX_W'(right);
        end else if (take_left) begin
          wdata = rdata_a_q;
          idx_d = mhpq_pkg::IDX_W'(left);
        end
      end
      mhpq_pkg::ST_DONE: begin
        push = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    root_d = root_q;
    if (we && (waddr == '0)) begin
      root_d = wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mhpq_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    key_q     <= key_d;
    root_q    <= root_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_q <= mem[raddr_a];
    rdata_b_q <= mem[raddr_b];
  end

  assign res.removed_value = removed_q;
  assign res.status        = status_q;
  assign res.top_value     = (count_q == '0) ? '0 : root_q;
  assign res.count         = mhpq_pkg::OCNT_W'(count_q);
  assign res.is_empty      = (count_q == '0);

  mhpq_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_data_i   (res),
    .push_ready_o  (push_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (mhpq_pkg::CNT_W'(waddr) < count_q))
    else $error("heap write outside live entries");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mhpq_pkg::ST_IDLE || state_q == mhpq_pkg::ST_DONE) |-> !we)
    else $error("heap write outside a sift");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (mhpq_pkg::kind_e'(s_axis_tuser) == mhpq_pkg::KIND_INSERT) &&
     count_q != mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
    |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not grow the heap");

  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mhpq_pkg::ST_IDLE) |=> $stable(count_q))
    else $error("count changed during a sift");

endmodule
